FILE: rtl/text_console_writer_defines.svh
// Assertion macros for the text console RTL.
// No dependencies; included by tcw_back, the module that carries assertions.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;
    localparam int QUEUE_DEPTH     = 2;

    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int ROW_F_W = 5;
    localparam int COL_F_W = 7;
    localparam int CELL_W  = 16;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'd240;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_PUT     = 3'd0;
    localparam kind_t KIND_NEWLINE = 3'd1;
    localparam kind_t KIND_CLEAR   = 3'd2;
    localparam kind_t KIND_READ    = 3'd3;
    localparam kind_t KIND_NULL    = 3'd4;  // out-of-range read or unused opcode

    typedef struct packed {
        kind_t               kind;
        logic [CHAR_W-1:0]   char_code;
        logic [ROW_F_W-1:0]  row;
        logic [COL_F_W-1:0]  col;
    } cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0]   cell_value;
        logic [COL_F_W-1:0]  cursor_col;
        logic [ROW_F_W-1:0]  cursor_row;
        logic                scrolled;
    } res_t;

endpackage

FILE: rtl/tcw_fifo.sv
// Small synchronous queue used between front and back and on the result side.
// Depends on tcw_pkg for the default depth.
`timescale 1ns / 1ps

module tcw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] data_in,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] data_out
);
    import tcw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign data_out = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= data_in;
        end
    end

endmodule

FILE: rtl/tcw_front.sv
// Input stage: takes operations, range-checks reads and tags each command.
// Depends on tcw_pkg for command types and opcodes.
`timescale 1ns / 1ps

module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [tcw_pkg::OP_W-1:0]      operation,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::ROW_F_W-1:0]   read_row,
    input  logic [tcw_pkg::COL_F_W-1:0]   read_col,
    output tcw_pkg::cmd_t                 cmd,
    output logic                          cmd_valid,
    input  logic                          cmd_ready
);
    import tcw_pkg::*;

    cmd_t  cmd_reg;
    cmd_t  cmd_next;
    logic  valid_reg;
    logic  stage_ready;
    logic  in_range;

    assign stage_ready = !valid_reg || cmd_ready;
    assign full        = !stage_ready;
    assign cmd         = cmd_reg;
    assign cmd_valid   = valid_reg;

    assign in_range = ({27'd0, read_row} < 32'(ROWS)) && ({25'd0, read_col} < 32'(COLUMNS));

    always_comb
    begin
        cmd_next.char_code = char_code;
        cmd_next.row       = read_row;
        cmd_next.col       = read_col;
        unique case (operation)
            OP_PUT:
            begin
                cmd_next.kind = (char_code == NEWLINE_CODE) ? KIND_NEWLINE : KIND_PUT;
            end
            OP_CLEAR:
            begin
                cmd_next.kind = KIND_CLEAR;
            end
            OP_READ:
            begin
                cmd_next.kind = in_range ? KIND_READ : KIND_NULL;
            end
            default:
            begin
                cmd_next.kind = KIND_NULL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push && stage_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && stage_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

FILE: rtl/tcw_back.sv
// Execution engine: screen store, cursor, row-offset scroll and clear walks.
// Depends on tcw_pkg and on text_console_writer_defines.svh for assertions.
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcw_pkg::COLOR_W-1:0]   text_color,
    input  tcw_pkg::cmd_t                 cmd,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  logic                          res_full,
    output logic                          res_push,
    output tcw_pkg::res_t                 res
);
    import tcw_pkg::*;

    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_CLEAR  = 3'd4;

    logic [2:0]        state_reg, state_next;
    cmd_t              cmd_reg;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_line_reg, cur_line_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ROW_W-1:0]  blank_row_reg, blank_row_next;
    logic [ADDR_W-1:0] walk_reg, walk_next;
    logic [CELL_W-1:0] rd_data_reg;

    logic [CELL_W-1:0] screen [CELLS];

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [ROW_W:0]    line_sum;
    logic [ROW_W-1:0]  line_phys;
    logic [ROW_W:0]    rd_sum;
    logic [ROW_W-1:0]  rd_phys;
    logic [COL_W:0]    col_inc;
    logic              is_newline;
    logic              line_adv;
    logic              at_bottom;
    logic [CELL_W-1:0] blank_cell;
    logic [ADDR_W-1:0] put_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] scroll_addr;

    assign blank_cell = {text_color, SPACE_CODE};

    // Logical row to physical row through the scroll offset.
    assign line_sum  = {1'b0, cur_line_reg} + {1'b0, top_reg};
    assign line_phys = (line_sum >= (ROW_W + 1)'(ROWS)) ?
                       ROW_W'(line_sum - (ROW_W + 1)'(ROWS)) : ROW_W'(line_sum);
    assign rd_sum    = {1'b0, ROW_W'(cmd_reg.row)} + {1'b0, top_reg};
    assign rd_phys   = (rd_sum >= (ROW_W + 1)'(ROWS)) ?
                       ROW_W'(rd_sum - (ROW_W + 1)'(ROWS)) : ROW_W'(rd_sum);

    assign put_addr    = ADDR_W'(int'(line_phys) * COLUMNS) + ADDR_W'(cur_col_reg);
    assign rd_addr     = ADDR_W'(int'(rd_phys) * COLUMNS) + ADDR_W'(COL_W'(cmd_reg.col));
    assign scroll_addr = ADDR_W'(int'(blank_row_reg) * COLUMNS)
                       + ADDR_W'(walk_reg[COL_W-1:0]);

    assign is_newline = (cmd_reg.kind == KIND_NEWLINE);
    assign col_inc    = {1'b0, cur_col_reg} + 1'b1;
    assign line_adv   = is_newline || (col_inc == (COL_W + 1)'(COLUMNS));
    assign at_bottom  = (cur_line_reg == ROW_W'(ROWS - 1));

    always_comb
    begin
        state_next     = state_reg;
        cur_col_next   = cur_col_reg;
        cur_line_next  = cur_line_reg;
        top_next       = top_reg;
        blank_row_next = blank_row_reg;
        walk_next      = walk_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = put_addr;
        mem_wdata      = blank_cell;
        mem_re         = 1'b0;
        mem_raddr      = rd_addr;
        res_push       = 1'b0;
        res.cell_value = '0;
        res.scrolled   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // One result per command, so a free result slot is reserved here.
                if (cmd_valid && !res_full)
                begin
                    cmd_pop    = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (cmd_reg.kind) inside
                    KIND_PUT, KIND_NEWLINE:
                    begin
                        if (!is_newline)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = put_addr;
                            mem_wdata = {text_color, cmd_reg.char_code};
                        end
                        cur_col_next = line_adv ? '0 : col_inc[COL_W-1:0];
                        if (line_adv && at_bottom)
                        begin
                            // Scroll: old top row becomes the new bottom row.
                            blank_row_next = top_reg;
                            top_next       = (top_reg == ROW_W'(ROWS - 1)) ?
                                             '0 : top_reg + 1'b1;
                            walk_next      = '0;
                            state_next     = ST_SCROLL;
                        end
                        else
                        begin
                            if (line_adv)
                            begin
                                cur_line_next = cur_line_reg + 1'b1;
                            end
                            res_push   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        walk_next  = '0;
                        state_next = ST_CLEAR;
                    end
                    KIND_READ:
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = rd_addr;
                        state_next = ST_READ;
                    end
                    default:
                    begin
                        res_push   = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ:
            begin
                res.cell_value = rd_data_reg;
                res_push       = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_SCROLL:
            begin
                mem_we    = 1'b1;
                mem_waddr = scroll_addr;
                walk_next = walk_reg + 1'b1;
                if (walk_reg == ADDR_W'(COLUMNS - 1))
                begin
                    res.scrolled = 1'b1;
                    res_push     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = walk_reg;
                walk_next = walk_reg + 1'b1;
                if (walk_reg == ADDR_W'(CELLS - 1))
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res.cursor_col = COL_F_W'(cur_col_next);
        res.cursor_row = ROW_F_W'(cur_line_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_col_reg   <= '0;
            cur_line_reg  <= '0;
            top_reg       <= '0;
            blank_row_reg <= '0;
            walk_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_line_reg  <= cur_line_next;
            top_reg       <= top_next;
            blank_row_reg <= blank_row_next;
            walk_reg      <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= screen[mem_raddr];
        end
    end

    `TCW_ASSERT_NOW(a_line_range, clk, rst_n, 1'b1, cur_line_reg <= ROW_W'(ROWS - 1),
        "cursor row beyond last row")
    `TCW_ASSERT_NOW(a_col_range, clk, rst_n, 1'b1, cur_col_reg <= COL_W'(COLUMNS - 1),
        "cursor column beyond last column")
    `TCW_ASSERT_NOW(a_res_room, clk, rst_n, res_push, !res_full,
        "result pushed into a full result queue")
    `TCW_ASSERT_NOW(a_no_idle_write, clk, rst_n,
        (state_reg == ST_IDLE) || (state_reg == ST_READ), !mem_we,
        "screen write outside an executing state")
    `TCW_ASSERT_NEXT(a_pop_exec, clk, rst_n, cmd_pop, state_reg == ST_EXEC,
        "dequeued command not executed next cycle")

endmodule

FILE: rtl/text_console_writer.sv
// Text console top level: front stage, command queue, engine, result queue.
// Depends on tcw_pkg, tcw_front, tcw_fifo and tcw_back.
//
//   Channel      Handshake                     Payload
//   input        push / full                   operation, char_code, read_row, read_col
//   result       empty / pop                   cell_value, cursor_col, cursor_row, scrolled
//   text_color   text_color_valid / _ready     text_color
//
// Engine steps per item: idle then execute for a character, newline, unused opcode or
// out-of-range read; a read adds a registered screen read; a scroll adds one blank write
// per cell of the new bottom row; a clear adds one blank write per cell of the screen.
// Scrolling moves a row offset, so no text is copied. No clearing pass after reset.
// Two-entry queues on both sides let input and output stall independently.
`timescale 1ns / 1ps

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [tcw_pkg::OP_W-1:0]      operation,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::ROW_F_W-1:0]   read_row,
    input  logic [tcw_pkg::COL_F_W-1:0]   read_col,
    output logic                          empty,
    input  logic                          pop,
    output logic [tcw_pkg::CELL_W-1:0]    cell_value,
    output logic [tcw_pkg::COL_F_W-1:0]   cursor_col,
    output logic [tcw_pkg::ROW_F_W-1:0]   cursor_row,
    output logic                          scrolled,
    input  logic                          text_color_valid,
    output logic                          text_color_ready,
    input  logic [tcw_pkg::COLOR_W-1:0]   text_color
);
    import tcw_pkg::*;

    logic [COLOR_W-1:0] color_reg;

    cmd_t front_cmd;
    logic front_valid;
    logic cmd_full;
    cmd_t queued_cmd;
    logic queued_valid;
    logic cmd_pop;
    logic res_full;
    logic res_push;
    res_t back_res;
    res_t head_res;
    logic res_valid;

    assign text_color_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= COLOR_RESET;
        end
        else if (text_color_valid)
        begin
            color_reg <= text_color;
        end
    end

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .char_code (char_code),
        .read_row  (read_row),
        .read_col  (read_col),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (!cmd_full)
    );

    tcw_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_valid),
        .full     (cmd_full),
        .data_in  (front_cmd),
        .pop      (cmd_pop),
        .valid    (queued_valid),
        .data_out (queued_cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_color (color_reg),
        .cmd        (queued_cmd),
        .cmd_valid  (queued_valid),
        .cmd_pop    (cmd_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (back_res)
    );

    tcw_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .full     (res_full),
        .data_in  (back_res),
        .pop      (pop),
        .valid    (res_valid),
        .data_out (head_res)
    );

    assign empty      = !res_valid;
    assign cell_value = head_res.cell_value;
    assign cursor_col = head_res.cursor_col;
    assign cursor_row = head_res.cursor_row;
    assign scrolled   = head_res.scrolled;

endmodule
